/* rtl/oks_pkg.sv */
// Package for the ordered key set: operation and status codes, FSM states, sizes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package oks_pkg;
    localparam int UNIVERSE_DEF = 1024;
    localparam int WORD_W = 64;
    localparam int KEY_W = 10;
    localparam int RES_W = 11;
    localparam int SIZE_W = 11;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    typedef enum logic [2:0] {
        OP_INSERT   = 3'd0,
        OP_ERASE    = 3'd1,
        OP_CONTAINS = 3'd2,
        OP_PRED     = 3'd3,
        OP_SUCC     = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ABSENT   = 2'd1,
        ST_RANGE    = 2'd2,
        ST_OCCUPIED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_READ,
        S_EVAL,
        S_SCAN,
        S_SCAN_EVAL,
        S_DONE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic clear;
        logic read_home;
        logic eval;
        logic scan_step;
        logic scan_eval;
        logic finish;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_done;
        logic need_scan;
        logic scan_hit;
        logic scan_end;
    } stat_t;
endpackage
`default_nettype wire

/* rtl/oks_if.sv */
// Valid/ready channel interfaces for requests and results.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface oks_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [9:0] key;
    modport source (output valid, operation, key, input ready);
    modport sink (input valid, operation, key, output ready);
endinterface

interface oks_res_if;
    logic              valid;
    logic              ready;
    logic signed [10:0] result_key;
    logic              present;
    logic [1:0]        status;
    modport source (output valid, result_key, present, status, input ready);
    modport sink (input valid, result_key, present, status, output ready);
endinterface
`default_nettype wire

/* rtl/oks_ram.sv */
// Generic single port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module oks_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  addr,
    input  wire [WIDTH-1:0]          wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

/* rtl/oks_ctrl.sv */
// Controller FSM for the ordered key set.
// Depends on oks_pkg.
`timescale 1ns / 1ps
`default_nettype none
module oks_ctrl (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire            out_ready,
    input  oks_pkg::stat_t stat,
    output oks_pkg::cmd_t  cmd
);
    oks_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= oks_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            oks_pkg::S_CLEAR:
                if (stat.clear_done) state_next = oks_pkg::S_IDLE;
            oks_pkg::S_IDLE:
                if (in_valid) state_next = oks_pkg::S_READ;
            oks_pkg::S_READ:
                state_next = oks_pkg::S_EVAL;
            oks_pkg::S_EVAL:
                state_next = stat.need_scan ? oks_pkg::S_SCAN : oks_pkg::S_DONE;
            oks_pkg::S_SCAN:
                state_next = oks_pkg::S_SCAN_EVAL;
            oks_pkg::S_SCAN_EVAL:
                if (stat.scan_hit || stat.scan_end) state_next = oks_pkg::S_DONE;
                else state_next = oks_pkg::S_SCAN;
            oks_pkg::S_DONE:
                if (out_ready) state_next = oks_pkg::S_IDLE;
            default:
                state_next = oks_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            oks_pkg::S_CLEAR:     cmd.clear = 1'b1;
            oks_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            oks_pkg::S_READ:      cmd.read_home = 1'b1;
            oks_pkg::S_EVAL:      cmd.eval = 1'b1;
            oks_pkg::S_SCAN:      cmd.scan_step = 1'b1;
            oks_pkg::S_SCAN_EVAL: cmd.scan_eval = 1'b1;
            oks_pkg::S_DONE:
            begin
                out_valid  = 1'b1;
                cmd.finish = out_ready;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

/* rtl/oks_dp.sv */
// Datapath: occupancy word memory, summary bits, bit search and result register.
// Depends on oks_pkg and oks_ram.
`timescale 1ns / 1ps
`default_nettype none
module oks_dp #(
    parameter int UNIVERSE = oks_pkg::UNIVERSE_DEF
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  oks_pkg::cmd_t                 cmd,
    output oks_pkg::stat_t                stat,
    input  wire [2:0]                     in_operation,
    input  wire [oks_pkg::KEY_W-1:0]      in_key,
    input  wire [oks_pkg::SIZE_W-1:0]     cfg_size,
    output logic signed [oks_pkg::RES_W-1:0] result_key,
    output logic                          present,
    output logic [1:0]                    status
);
    localparam int W     = oks_pkg::WORD_W;
    localparam int WORDS = (UNIVERSE + W - 1) / W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW    = $clog2(W);
    localparam int KW    = oks_pkg::KEY_W;
    localparam logic [oks_pkg::RES_W-1:0] NONE = '1;

    logic [2:0]        op_reg;
    logic [KW-1:0]     key_reg;
    logic [oks_pkg::SIZE_W-1:0] size_reg;
    logic [AW-1:0]     widx_reg, widx_next;
    logic [AW:0]       clr_reg;
    logic [WORDS-1:0]  sum_reg;
    logic [oks_pkg::RES_W-1:0] res_reg;
    logic              pres_reg;
    logic [1:0]        stat_reg;

    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [W-1:0]      ram_wdata, ram_rdata;

    oks_ram #(.WIDTH(W), .DEPTH(1 << AW)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    logic [AW-1:0] home_w;
    logic [BW-1:0] home_b;
    logic          in_range;
    logic          bit_now;
    logic [W-1:0]  below_m, above_m, new_word;
    logic [BW-1:0] top_below, low_above, top_all, low_all;
    logic          any_below, any_above;
    logic [WORDS-1:0] sum_new;
    logic          scan_ok;
    logic [oks_pkg::SIZE_W:0] cand_key, eff_size;

    assign home_w  = AW'(key_reg >> BW);
    assign home_b  = key_reg[BW-1:0];
    assign eff_size = ({1'b0, size_reg} > (oks_pkg::SIZE_W+1)'(UNIVERSE))
                      ? (oks_pkg::SIZE_W+1)'(UNIVERSE) : {1'b0, size_reg};
    assign in_range = ({2'b0, key_reg} < eff_size);
    assign bit_now  = ram_rdata[home_b];
    assign below_m  = ram_rdata & ((W'(1) << home_b) - W'(1));
    assign above_m  = ram_rdata & ~((W'(2) << home_b) - W'(1));
    assign any_below = |below_m;
    assign any_above = |above_m;

    // Priority encoders over one word
    always_comb
    begin
        top_below = '0;
        low_above = '0;
        top_all   = '0;
        low_all   = '0;
        for (int i = 0; i < W; i++)
        begin
            if (below_m[i]) top_below = BW'(i);
            if (ram_rdata[i]) top_all = BW'(i);
        end
        for (int i = W - 1; i >= 0; i--)
        begin
            if (above_m[i]) low_above = BW'(i);
            if (ram_rdata[i]) low_all = BW'(i);
        end
    end

    // Insert or erase new word and its summary bit
    always_comb
    begin
        new_word = ram_rdata;
        if (op_reg == oks_pkg::OP_INSERT) new_word[home_b] = 1'b1;
        else new_word[home_b] = 1'b0;
        sum_new = sum_reg;
        sum_new[home_w] = |new_word;
    end

    logic is_write;
    assign is_write = cmd.eval && in_range &&
                      ((op_reg == oks_pkg::OP_INSERT) ||
                       (op_reg == oks_pkg::OP_ERASE && bit_now));

    // Scan target: adjacent word in search direction
    always_comb
    begin
        widx_next = widx_reg;
        scan_ok   = 1'b0;
        if (op_reg == oks_pkg::OP_PRED)
        begin
            if (widx_reg != '0)
            begin
                widx_next = widx_reg - AW'(1);
                scan_ok   = 1'b1;
            end
        end
        else if ({1'b0, widx_reg} < (AW+1)'(WORDS - 1))
        begin
            widx_next = widx_reg + AW'(1);
            scan_ok   = 1'b1;
        end
    end

    // Address the word that the next state evaluates
    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = new_word;
        ram_addr  = widx_reg;
        if (cmd.clear)
        begin
            ram_we    = 1'b1;
            ram_wdata = '0;
            ram_addr  = clr_reg[AW-1:0];
        end
        else if (is_write)
        begin
            ram_we   = 1'b1;
            ram_addr = home_w;
        end
        else if (cmd.read_home)
        begin
            ram_addr = home_w;
        end
        else if (cmd.scan_step)
        begin
            ram_addr = widx_next;
        end
    end

    assign stat.clear_done = clr_reg == (AW+1)'((1 << AW) - 1);
    assign stat.need_scan  = in_range && scan_ok &&
                             ((op_reg == oks_pkg::OP_PRED && !any_below) ||
                              (op_reg == oks_pkg::OP_SUCC && !any_above));
    assign stat.scan_hit   = sum_reg[widx_reg];
    assign stat.scan_end   = !scan_ok;
    assign cand_key = (oks_pkg::SIZE_W+1)'({widx_reg,
                      (op_reg == oks_pkg::OP_PRED) ? top_all : low_all});

    // Clear sweep counter and summary bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            if (cmd.clear && !stat.clear_done) clr_reg <= clr_reg + (AW+1)'(1);
            if (is_write) sum_reg <= sum_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) size_reg <= oks_pkg::SIZE_RESET;
        else size_reg <= cfg_size;
    end

    // Request and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= in_operation;
            key_reg <= in_key;
        end
        if (cmd.read_home) widx_reg <= home_w;
        if (cmd.eval)
        begin
            res_reg  <= NONE;
            pres_reg <= in_range & bit_now;
            stat_reg <= oks_pkg::ST_OK;
            if (!in_range) stat_reg <= oks_pkg::ST_RANGE;
            else if (op_reg == oks_pkg::OP_INSERT && bit_now) stat_reg <= oks_pkg::ST_OCCUPIED;
            else if (op_reg == oks_pkg::OP_ERASE && !bit_now) stat_reg <= oks_pkg::ST_ABSENT;
            if (in_range && op_reg == oks_pkg::OP_PRED && any_below)
                res_reg <= oks_pkg::RES_W'({home_w, top_below});
            if (in_range && op_reg == oks_pkg::OP_SUCC && any_above &&
                ({1'b0, home_w, low_above} < eff_size))
                res_reg <= oks_pkg::RES_W'({home_w, low_above});
        end
        if (cmd.scan_step) widx_reg <= widx_next;
        if (cmd.scan_eval && stat.scan_hit)
        begin
            if (op_reg == oks_pkg::OP_PRED || cand_key < eff_size)
                res_reg <= oks_pkg::RES_W'(cand_key);
        end
    end

    assign result_key = res_reg;
    assign present    = pres_reg;
    assign status     = stat_reg;
endmodule
`default_nettype wire

/* rtl/ordered_key_set_pred_succ_top.sv */
// Top level of the ordered key set with predecessor and successor search.
// Depends on oks_pkg, oks_if, oks_ctrl, oks_dp.
//
// One request at a time. After reset the occupancy memory is swept clear, one
// 64-key word a cycle, before the first request is taken. Insert, erase and
// contains pass through the read and evaluate states to a result; a
// predecessor or successor whose home word holds no answer walks the word
// memory a word at a time through the scan and scan-evaluate states, using
// summary flip-flops to stop at the first used word.
`timescale 1ns / 1ps
`default_nettype none
module ordered_key_set_pred_succ_top #(
    parameter int UNIVERSE = oks_pkg::UNIVERSE_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        cfg_we,
    input  wire [10:0] cfg_wdata,
    oks_req_if.sink    req,
    oks_res_if.source  res
);
    oks_pkg::cmd_t  cmd;
    oks_pkg::stat_t stat;
    logic [10:0] size_reg, size_next;

    // Hold the universe size register
    always_comb
    begin
        size_next = cfg_we ? cfg_wdata : size_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) size_reg <= oks_pkg::SIZE_RESET;
        else size_reg <= size_next;
    end

    oks_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    oks_dp #(.UNIVERSE(UNIVERSE)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_operation (req.operation),
        .in_key       (req.key),
        .cfg_size     (size_reg),
        .result_key   (res.result_key),
        .present      (res.present),
        .status       (res.status)
    );
endmodule
`default_nettype wire

/* rtl/oks_checker.sv */
// Port level checker for the ordered key set, bound to the top level.
// Depends on oks_pkg.
`timescale 1ns / 1ps
`default_nettype none
module oks_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        req_valid,
    input wire        req_ready,
    input wire        res_valid,
    input wire        res_ready,
    input wire [10:0] res_result_key,
    input wire [1:0]  res_status
);
    // One request at a time: no request taken while a result waits
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !req_ready) else $error("request taken during result");

    // A taken request does not produce a result in the next cycle
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !res_valid) else $error("result too early");

    // Out of range gives no search result
    a_rng: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_status == oks_pkg::ST_RANGE) |-> res_result_key == 11'h7FF)
        else $error("range error with key");

    // Result holds while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_result_key)))
        else $error("result dropped");
endmodule

bind ordered_key_set_pred_succ_top oks_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .res_result_key (res.result_key),
    .res_status     (res.status)
);
`default_nettype wire

/* tb/sv/oks_tb_checker.sv */
// Checker for the ordered key set: watches the request and result channels,
// predicts each result from its own copy of the key set, and counts mismatches.
// Depends on oks_pkg.
`timescale 1ns / 1ps
`default_nettype none
module oks_tb_checker
    import oks_pkg::*;
#(
    parameter int UNIVERSE = 1024
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cfg_we,
    input  wire [SIZE_W-1:0]   cfg_wdata,
    input  wire                req_valid,
    input  wire                req_ready,
    input  wire [2:0]          req_operation,
    input  wire [KEY_W-1:0]    req_key,
    input  wire                res_valid,
    input  wire                res_ready,
    input  wire [RES_W-1:0]    res_result_key,
    input  wire                res_present,
    input  wire [1:0]          res_status,
    output int                 fail_count,
    output int                 pending_count
);
    localparam logic [RES_W-1:0] NO_KEY = '1;

    typedef struct packed {
        logic [RES_W-1:0] result_key;
        logic             present;
        status_t          status;
    } answer_t;

    logic [UNIVERSE-1:0] key_bits;
    logic [SIZE_W-1:0]   set_size;
    answer_t             answer_q[$];

    assign pending_count = answer_q.size();

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // Compute the result of one request and update the key set
    function automatic answer_t apply_request(input logic [2:0] op, input int key);
        answer_t a;
        int lim;
        int j;
        lim = (set_size > UNIVERSE) ? UNIVERSE : int'(set_size);
        a.result_key = NO_KEY;
        a.present = 1'b0;
        a.status = ST_OK;
        if (key >= lim) begin
            a.status = ST_RANGE;
            return a;
        end
        a.present = key_bits[key];
        case (op)
            OP_INSERT:
            begin
                if (a.present) a.status = ST_OCCUPIED;
                key_bits[key] = 1'b1;
            end
            OP_ERASE:
            begin
                if (!a.present) a.status = ST_ABSENT;
                else key_bits[key] = 1'b0;
            end
            OP_PRED:
            begin
                for (j = key - 1; j >= 0; j--)
                    if (key_bits[j])
                    begin
                        a.result_key = RES_W'(j);
                        break;
                    end
            end
            OP_SUCC:
            begin
                // keys past the size are stored but not returned
                for (j = key + 1; j < UNIVERSE; j++)
                    if (key_bits[j])
                    begin
                        if (j < lim) a.result_key = RES_W'(j);
                        break;
                    end
            end
            default: ;
        endcase
        return a;
    endfunction

    // Track config, predict on accept, compare on result
    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            key_bits <= '0;
            set_size <= SIZE_RESET;
            answer_q.delete();
            fail_count <= 0;
        end
        else
        begin
            if (cfg_we) set_size = cfg_wdata;
            if (req_valid && req_ready)
                answer_q.push_back(apply_request(req_operation, int'(req_key)));
            if (res_valid && res_ready)
            begin
                if (answer_q.size() == 0)
                    report_mismatch("unexpected result", 1, 0);
                else
                begin
                    want = answer_q.pop_front();
                    if (res_result_key != want.result_key)
                        report_mismatch("result_key", $signed(res_result_key),
                            $signed(want.result_key));
                    if (res_present != want.present)
                        report_mismatch("present", res_present, want.present);
                    if (res_status != want.status)
                        report_mismatch("status", res_status, want.status);
                end
            end
        end
    end
endmodule
`default_nettype wire

/* tb/sv/ordered_key_set_pred_succ_top_tb.sv */
// Testbench top for the ordered key set: drives requests, configuration and
// result stalls, and gives the verdict from the checker's count.
// Depends on oks_pkg, oks_if, oks_tb_checker and the block.
`timescale 1ns / 1ps
`default_nettype none
module ordered_key_set_pred_succ_top_tb;
    import oks_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [SIZE_W-1:0] cfg_wdata = '0;
    int sender_idle = 0;
    int receiver_stall = 0;
    bit hold_off = 1'b0;
    int fail_count;
    int pending_count;

    oks_req_if req();
    oks_res_if res();

    ordered_key_set_pred_succ_top DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .req(req.sink), .res(res.source)
    );

    oks_tb_checker checker_u (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .req_valid(req.valid), .req_ready(req.ready),
        .req_operation(req.operation), .req_key(req.key),
        .res_valid(res.valid), .res_ready(res.ready),
        .res_result_key(res.result_key), .res_present(res.present),
        .res_status(res.status),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always #1 clk = ~clk;

    initial
    begin
        req.valid = 1'b0;
        req.operation = '0;
        req.key = '0;
        res.ready = 1'b0;
    end

    // Stall the result side at random, or hold off for a long stretch
    always @(posedge clk)
    begin
        if (!rst_n || hold_off) res.ready <= 1'b0;
        else res.ready <= ($urandom_range(99) >= receiver_stall);
    end

    // Send one item; wait for the handshake, then drop valid
    task automatic send_item(input logic [2:0] op, input logic [KEY_W-1:0] key);
        while ($urandom_range(99) < sender_idle)
            @(posedge clk);
        req.valid <= 1'b1;
        req.operation <= op;
        req.key <= key;
        do @(posedge clk); while (!req.ready);
        req.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_results;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] v);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly well-formed traffic, keys mostly below the span, some at word edges
    task automatic random_items(input int n, input int span);
        int i;
        int k;
        for (i = 0; i < n; i++)
        begin
            case ($urandom_range(9))
                0: k = $urandom_range(1023);
                1: k = ($urandom_range(15) * 64) + ($urandom_range(1) ? 63 : 0);
                default: k = $urandom_range(span - 1);
            endcase
            send_item(($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
                : 3'($urandom_range(4)), KEY_W'(k));
        end
    endtask

    initial
    begin
        int phase;
        int i;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty searches, extremes, every operation and error case
        send_item(OP_PRED, 10'd0);
        send_item(OP_SUCC, 10'd1023);
        send_item(OP_ERASE, 10'd5);
        send_item(OP_INSERT, 10'd0);
        send_item(OP_INSERT, 10'd1023);
        send_item(OP_INSERT, 10'd1023);
        send_item(OP_INSERT, 10'd500);
        send_item(OP_CONTAINS, 10'd500);
        send_item(OP_SUCC, 10'd0);
        send_item(OP_PRED, 10'd1023);
        send_item(OP_PRED, 10'd499);
        send_item(OP_SUCC, 10'd600);
        send_item(3'd5, 10'd500);
        send_item(3'd7, 10'd1);
        send_item(OP_ERASE, 10'd500);
        send_item(OP_SUCC, 10'd1);
        write_size(11'd600);
        send_item(OP_INSERT, 10'd700);
        send_item(OP_SUCC, 10'd1);
        send_item(OP_PRED, 10'd599);
        write_size(11'd0);
        send_item(OP_CONTAINS, 10'd0);
        write_size(11'h7FF);
        send_item(OP_SUCC, 10'd0);
        send_item(OP_ERASE, 10'd1023);
        write_size(11'd1);
        send_item(OP_INSERT, 10'd0);

        // Random phases across idling mixes and sizes
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin sender_idle = 0; receiver_stall = 0; end
                1: begin sender_idle = 80; receiver_stall = 0; end
                2: begin sender_idle = 0; receiver_stall = 80; end
                default: begin sender_idle = 33; receiver_stall = 33; end
            endcase
            case (phase)
                0: write_size(11'd1024);
                1: write_size(11'd64);
                2: write_size(11'd1);
                3: write_size(11'd2047);
                4: write_size(11'd1024);
                default: write_size(11'($urandom_range(1024, 2)));
            endcase
            random_items(170, (phase == 2) ? 2 : (phase == 1) ? 64 : 1024);
        end

        // Long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_off = 1'b1;
                for (i = 0; i < 300; i++) @(posedge clk);
                hold_off = 1'b0;
            end
            random_items(20, 1024);
        join
        drain_results();
        random_items(20, 1024);
        drain_results();

        if (fail_count == 0)
            $display("ordered_key_set_pred_succ_top_tb: PASS");
        else
            $display("ordered_key_set_pred_succ_top_tb: FAIL");
        $finish;
    end

    // Guard against a hung run
    initial
    begin
        #2000000;
        $display("ordered_key_set_pred_succ_top_tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
